// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked assertion, disabled while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Assertion that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ===== sv/pdle_pkg.sv =====
// Package: types and constants of the packet delay and loss emulator.
`timescale 1ns / 1ps
`default_nettype none
package pdle_pkg;
  localparam int QUEUE_DEPTH = 16;
  localparam int MAX_RESULTS = 16;
  localparam int SLOT_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int RES_W  = $clog2(MAX_RESULTS + 1);
  localparam logic [63:0] RNG_MULT = 64'h2545F4914F6CDD1D;
  localparam logic [47:0] MASK48 = '1;

  localparam logic [1:0] ADDR_LATENCY = 2'd0;
  localparam logic [1:0] ADDR_JITTER  = 2'd1;
  localparam logic [1:0] ADDR_LOSS    = 2'd2;
  localparam logic [1:0] ADDR_SEED    = 2'd3;

  localparam logic [1:0] ST_QUEUED = 2'd0;
  localparam logic [1:0] ST_LOST   = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  localparam logic KIND_STATUS  = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;
  localparam logic REQ_ENQ = 1'b0;
  localparam logic REQ_ADV = 1'b1;
endpackage
`default_nettype wire

// ===== sv/packet_delay_loss_emulator_core.sv =====
// Top level: packet delay and loss emulator core.
// channel | direction | handshake          | payload
// in_     | input     | in_valid/in_ready  | request fields
// out_    | output    | out_valid/out_ready| result fields
// cfg_    | APB slave | psel/penable/pready| 64-bit registers at 8*i
// Enqueue: no draw, a loss draw, a jitter draw, or both, jitter first (a draw is three
// xorshift steps and four 16x64 partial products through one shared multiplier; jitter
// scaling adds two more partial products and one step to apply), then due and enqueue.
// Advance: per release a scan of the QUEUE_DEPTH slots, a pick step and an output step;
// with nothing due, one scan and no result. A stalled receiver holds the output step.
// Reset is synchronous; clears the queue valid bits, clock and serial.
// The block holds in_ready low from acceptance until its last result is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module packet_delay_loss_emulator_core import pdle_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_req_type,
  input  wire logic [15:0] in_dest_peer,
  input  wire logic        in_to_all,
  input  wire logic        in_channel,
  input  wire logic [31:0] in_payload_handle,
  input  wire logic [23:0] in_elapsed_ticks,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_kind,
  output logic [1:0]       out_status,
  output logic [15:0]      out_out_peer,
  output logic             out_out_to_all,
  output logic             out_out_channel,
  output logic [31:0]      out_out_payload,
  output logic [47:0]      out_due_time,
  output logic             out_last,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [63:0] cfg_pwdata,
  output logic [63:0]      cfg_prdata,
  output logic             cfg_pready
);
  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_XS    = 11'b00000000010,
    S_MUL   = 11'b00000000100,
    S_JIT   = 11'b00000001000,
    S_LOSS  = 11'b00000010000,
    S_DUE   = 11'b00000100000,
    S_ENQ   = 11'b00001000000,
    S_SCAN  = 11'b00010000000,
    S_PICK  = 11'b00100000000,
    S_OUT   = 11'b01000000000,
    S_JMUL  = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [23:0] lat_r, jit_r;
  logic [15:0] loss_r;
  logic [63:0] seed_r;
  logic cfg_wr;
  logic [1:0] cfg_idx;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx = cfg_paddr[4:3];

  always_comb begin
    case (cfg_idx)
      ADDR_LATENCY: cfg_prdata = {40'd0, lat_r};
      ADDR_JITTER:  cfg_prdata = {40'd0, jit_r};
      ADDR_LOSS:    cfg_prdata = {48'd0, loss_r};
      ADDR_SEED:    cfg_prdata = seed_r;
      default:      cfg_prdata = '0;
    endcase
  end

  // state
  logic [47:0] now_r;
  logic [63:0] rng_r;
  logic [31:0] serial_r;
  logic [QUEUE_DEPTH-1:0] sv_r;
  logic [47:0] sdue_r [QUEUE_DEPTH];
  logic [31:0] sser_r [QUEUE_DEPTH];
  logic [49:0] sdesc_r [QUEUE_DEPTH];

  // request hold
  logic [49:0] desc_r;
  logic        chan_r;

  // sequencing
  logic [1:0]  xs_r;      // xorshift step
  logic [2:0]  mstep_r;   // partial product index
  logic        draw_r;    // 0 jitter draw, 1 loss draw
  logic [63:0] acc_r;     // multiply accumulator
  logic [52:0] r53_r;
  logic signed [27:0] delta_r;
  logic [SLOT_W-1:0] idx_r;
  logic        best_ok_r;
  logic [SLOT_W-1:0] best_r;
  logic [RES_W-1:0] nres_r;
  logic        hit_r;
  logic [1:0]  elig_r;    // due slots seen in this scan, saturates at two

  // shared multiplier: 16 x 64, one partial product per cycle
  logic [15:0] mul_a;
  logic [63:0] mul_b;
  logic [79:0] mul_p;
  always_comb begin
    mul_a = 16'd0;
    mul_b = 64'd0;
    if (state_r == S_MUL) begin
      mul_a = RNG_MULT[16*mstep_r[1:0] +: 16];
      mul_b = rng_r;
    end else if (state_r == S_JMUL) begin
      mul_a = (mstep_r[0]) ? {8'd0, jit_r[23:16]} : jit_r[15:0];
      mul_b = {11'd0, r53_r};
    end
  end
  assign mul_p = mul_a * mul_b;

  // output register
  logic        ov_r;
  logic        okind_r, olast_r;
  logic [1:0]  ost_r;
  logic [49:0] odesc_r;
  logic [47:0] odue_r;
  assign out_valid = ov_r;
  assign out_kind = okind_r;
  assign out_status = ost_r;
  assign out_out_peer = odesc_r[15:0];
  assign out_out_to_all = odesc_r[16];
  assign out_out_channel = odesc_r[17];
  assign out_out_payload = odesc_r[49:18];
  assign out_due_time = odue_r;
  assign out_last = olast_r;
  assign in_ready = (state_r == S_IDLE) && !ov_r;

  // due time from delta
  logic signed [49:0] due_s;
  logic [47:0] due_c;
  always_comb begin
    due_s = $signed({2'b00, now_r}) + 50'(delta_r);
    if (delta_r < 0) due_c = now_r;
    else if (due_s[49:48] != 2'b00) due_c = MASK48;
    else due_c = due_s[47:0];
  end

  // free slot search
  logic free_ok;
  logic [SLOT_W-1:0] free_idx;
  always_comb begin
    free_ok = 1'b0;
    free_idx = '0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (!sv_r[i]) begin
        free_ok = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  // scan compare for current slot
  logic ripe;
  logic better;
  assign ripe = sv_r[idx_r] && (sdue_r[idx_r] <= now_r);
  always_comb begin
    better = 1'b0;
    if (ripe) begin
      if (!best_ok_r || sdue_r[idx_r] < sdue_r[best_r])
        better = 1'b1;
      else if (sdue_r[idx_r] == sdue_r[best_r] &&
               (serial_r - sser_r[idx_r]) > (serial_r - sser_r[best_r]))
        better = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid && in_ready) begin
        if (in_req_type == REQ_ADV) state_nxt = S_SCAN;
        else if (jit_r != 0 || loss_r != 0) state_nxt = S_XS;
        else state_nxt = S_DUE;
      end
      S_XS:   if (xs_r == 2'd2) state_nxt = S_MUL;
      S_MUL:  if (mstep_r == 3'd3) state_nxt = draw_r ? S_LOSS : S_JMUL;
      S_JMUL: if (mstep_r == 3'd1) state_nxt = S_JIT;
      S_JIT:  state_nxt = (loss_r != 0) ? S_XS : S_DUE;
      S_LOSS: state_nxt = S_DUE;
      S_DUE:  state_nxt = S_ENQ;
      S_ENQ:  state_nxt = S_IDLE;
      S_SCAN: if (idx_r == SLOT_W'(QUEUE_DEPTH - 1)) state_nxt = S_PICK;
      S_PICK: state_nxt = S_OUT;
      S_OUT:  if (!ov_r || out_ready) state_nxt = (hit_r) ? S_SCAN : S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  logic [63:0] xs_v;
  always_comb begin
    case (xs_r)
      2'd0:    xs_v = rng_r ^ (rng_r >> 12);
      2'd1:    xs_v = rng_r ^ (rng_r << 25);
      default: xs_v = rng_r ^ (rng_r >> 27);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      lat_r <= '0; jit_r <= '0; loss_r <= '0; seed_r <= '0;
      now_r <= '0; rng_r <= 64'd1; serial_r <= '0; sv_r <= '0;
      ov_r <= 1'b0; xs_r <= '0; mstep_r <= '0; draw_r <= 1'b0;
      idx_r <= '0; best_ok_r <= 1'b0; nres_r <= '0; hit_r <= 1'b0;
      elig_r <= '0;
    end else begin
      state_r <= state_nxt;
      // transfer taken; a release loaded in the same cycle keeps it set
      if (ov_r && out_ready && !(state_r == S_OUT && best_ok_r)) ov_r <= 1'b0;
      // register writes
      if (cfg_wr) begin
        case (cfg_idx)
          ADDR_LATENCY: lat_r <= cfg_pwdata[23:0];
          ADDR_JITTER:  jit_r <= cfg_pwdata[23:0];
          ADDR_LOSS:    loss_r <= cfg_pwdata[15:0];
          ADDR_SEED: begin
            seed_r <= cfg_pwdata;
            rng_r <= (cfg_pwdata == 64'd0) ? 64'd1 : cfg_pwdata;
          end
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: if (in_valid && in_ready) begin
          chan_r <= in_channel;
          desc_r <= {in_payload_handle, in_channel, in_to_all,
                     in_to_all ? 16'd0 : in_dest_peer};
          delta_r <= 28'(lat_r);
          draw_r <= (jit_r == 0);
          xs_r <= '0;
          mstep_r <= '0;
          hit_r <= 1'b0;
          idx_r <= '0;
          best_ok_r <= 1'b0;
          nres_r <= '0;
          elig_r <= '0;
          if (in_req_type == REQ_ADV) now_r <= now_r + 48'(in_elapsed_ticks);
        end
        S_XS: begin
          rng_r <= xs_v;
          xs_r <= xs_r + 2'd1;
          acc_r <= '0;
        end
        S_MUL: begin
          acc_r <= acc_r + (mul_p[63:0] << (16 * mstep_r[1:0]));
          mstep_r <= (mstep_r == 3'd3) ? 3'd0 : mstep_r + 3'd1;
          if (mstep_r == 3'd3)
            r53_r <= 53'((acc_r + (mul_p[63:0] << 48)) >> 11);
        end
        S_JMUL: begin
          // r53 * jit, as two partial products; result shifted right 16
          if (mstep_r == 3'd0) begin
            acc_r <= mul_p[79:16];
            mstep_r <= 3'd1;
          end else begin
            acc_r <= acc_r + mul_p[63:0];
            mstep_r <= 3'd0;
          end
        end
        S_JIT: begin
          // acc = floor(r53*j/2^16); scaled = acc >> 36 (total 2^52)
          delta_r <= delta_r + 28'(acc_r[63:36]) - 28'(jit_r);
          draw_r <= 1'b1;
          xs_r <= '0;
        end
        S_LOSS: begin
          if (r53_r < ({37'd0, loss_r} << 37)) begin
            hit_r <= 1'b1;
            delta_r <= delta_r + 28'({lat_r, 1'b0});
          end
        end
        S_DUE: begin
          if (hit_r && chan_r) begin
            ov_r <= 1'b1; okind_r <= KIND_STATUS; ost_r <= ST_LOST;
            odesc_r <= desc_r; odue_r <= '0; olast_r <= 1'b1;
          end else begin
            odue_r <= due_c;
          end
        end
        S_ENQ: begin
          if (!(hit_r && chan_r)) begin
            ov_r <= 1'b1; okind_r <= KIND_STATUS; odesc_r <= desc_r;
            olast_r <= 1'b1;
            if (free_ok) begin
              ost_r <= ST_QUEUED;
              sv_r[free_idx] <= 1'b1;
              sdue_r[free_idx] <= odue_r;
              sser_r[free_idx] <= serial_r;
              sdesc_r[free_idx] <= desc_r;
              serial_r <= serial_r + 32'd1;
            end else begin
              ost_r <= ST_FULL;
            end
          end
        end
        S_SCAN: begin
          if (better) begin
            best_r <= idx_r;
            best_ok_r <= 1'b1;
          end
          if (ripe && elig_r != 2'd2) elig_r <= elig_r + 2'd1;
          idx_r <= idx_r + SLOT_W'(1);
        end
        S_PICK: begin
          // another scan follows only if a second due slot exists
          hit_r <= best_ok_r && (elig_r == 2'd2) &&
                   (nres_r != RES_W'(MAX_RESULTS - 1));
        end
        S_OUT: if (!ov_r || out_ready) begin
          if (best_ok_r) begin
            ov_r <= 1'b1; okind_r <= KIND_RELEASE; ost_r <= ST_QUEUED;
            odesc_r <= sdesc_r[best_r]; odue_r <= sdue_r[best_r];
            olast_r <= !hit_r;
            sv_r[best_r] <= 1'b0;
            nres_r <= nres_r + RES_W'(1);
          end
          best_ok_r <= 1'b0;
          elig_r <= '0;
          idx_r <= '0;
        end
        default: ;
      endcase
    end
  end

  `ASSERT_CLK(a_ready_idle, clk, rst_n, in_ready |-> state_r == S_IDLE, "ready outside idle")
  `ASSERT_CLK(a_out_hold, clk, rst_n, (ov_r && !out_ready) |=> ov_r, "result lost while stalled")
  `ASSERT_CLK(a_onehot, clk, rst_n, $onehot(state_r), "state not one-hot")
endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// Testbench for the packet delay and loss emulator core: predicts every result and checks it.
`timescale 1ns / 1ps
`default_nettype none
module testbench import pdle_pkg::*; ();

  typedef struct packed {
    logic        kind;
    logic [1:0]  status;
    logic [15:0] peer;
    logic        to_all;
    logic        channel;
    logic [31:0] payload;
    logic [47:0] due;
    logic        last;
  } release_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_req_type = 1'b0;
  logic [15:0] in_dest_peer = '0;
  logic in_to_all = 1'b0;
  logic in_channel = 1'b0;
  logic [31:0] in_payload_handle = '0;
  logic [23:0] in_elapsed_ticks = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_kind;
  logic [1:0] out_status;
  logic [15:0] out_out_peer;
  logic out_out_to_all;
  logic out_out_channel;
  logic [31:0] out_out_payload;
  logic [47:0] out_due_time;
  logic out_last;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [4:0] cfg_paddr = '0;
  logic [63:0] cfg_pwdata = '0;
  logic [63:0] cfg_prdata;
  logic cfg_pready;

  packet_delay_loss_emulator_core u_dut (.*);

  // Predictor state
  logic [23:0] lat_q, jit_q;
  logic [15:0] loss_q;
  logic [63:0] rng_q;
  logic [47:0] now_q;
  logic [31:0] serial_q;
  logic        sv_q [QUEUE_DEPTH];
  logic [47:0] sdue_q [QUEUE_DEPTH];
  logic [31:0] sser_q [QUEUE_DEPTH];
  logic [49:0] sdesc_q [QUEUE_DEPTH];

  // Expected results, in order
  localparam int EXP_DEPTH = 1024;
  release_t exp_buf [EXP_DEPTH];
  int wr_idx = 0;
  int rd_idx = 0;
  int errors = 0;
  int send_idle = 0;
  int recv_idle = 0;
  longint cycles = 0;

  function automatic void add_exp(release_t r);
    exp_buf[wr_idx % EXP_DEPTH] = r;
    wr_idx++;
  endfunction

  initial forever #5 clk = ~clk;

  // Timeout guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver stall pattern
  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_idle);

  // Result checker
  always @(posedge clk) begin
    release_t got, exp_r;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_kind, out_status, out_out_peer, out_out_to_all, out_out_channel,
              out_out_payload, out_due_time, out_last};
      if (rd_idx == wr_idx) begin
        $error("unexpected result transfer");
        errors++;
      end else begin
        exp_r = exp_buf[rd_idx % EXP_DEPTH];
        rd_idx++;
        if (got.kind != exp_r.kind) begin $error("kind exp %0h got %0h", exp_r.kind, got.kind); errors++; end
        if (got.status != exp_r.status) begin $error("status exp %0h got %0h", exp_r.status, got.status); errors++; end
        if (got.peer != exp_r.peer) begin $error("out_peer exp %0h got %0h", exp_r.peer, got.peer); errors++; end
        if (got.to_all != exp_r.to_all) begin $error("out_to_all exp %0h got %0h", exp_r.to_all, got.to_all); errors++; end
        if (got.channel != exp_r.channel) begin $error("out_channel exp %0h got %0h", exp_r.channel, got.channel); errors++; end
        if (got.payload != exp_r.payload) begin $error("out_payload exp %0h got %0h", exp_r.payload, got.payload); errors++; end
        if (got.due != exp_r.due) begin $error("due_time exp %0h got %0h", exp_r.due, got.due); errors++; end
        if (got.last != exp_r.last) begin $error("last exp %0h got %0h", exp_r.last, got.last); errors++; end
      end
    end
  end

  function automatic logic [52:0] next_r53();
    logic [63:0] s;
    logic [63:0] p;
    s = rng_q;
    s = s ^ (s >> 12);
    s = s ^ (s << 25);
    s = s ^ (s >> 27);
    rng_q = s;
    p = s * RNG_MULT;
    return p[63:11];
  endfunction

  function automatic release_t mk(logic kind, logic [1:0] st, logic [49:0] d,
                                  logic [47:0] due, logic last);
    return '{kind, st, d[15:0], d[16], d[17], d[49:18], due, last};
  endfunction

  // Enqueue prediction
  task automatic predict_enqueue(logic [15:0] peer, logic ta, logic ch, logic [31:0] pl);
    logic [49:0] d;
    longint delta;
    logic [105:0] prod;
    logic [63:0] t;
    logic [48:0] due;
    int freei;
    d = {pl, ch, ta, (ta ? 16'd0 : peer)};
    delta = longint'(lat_q);
    if (jit_q != 0) begin
      prod = {53'd0, next_r53()} * 106'(jit_q);
      t = 64'(prod >> 52);
      delta += longint'(t) - longint'(jit_q);
    end
    if (loss_q != 0 && {11'd0, next_r53()} < ({48'd0, loss_q} << 37)) begin
      if (ch) begin
        add_exp(mk(KIND_STATUS, ST_LOST, d, 48'd0, 1'b1));
        return;
      end
      delta += 2 * longint'(lat_q);
    end
    if (delta < 0) delta = 0;
    due = {1'b0, now_q} + 49'(delta);
    if (due[48]) due = {1'b0, MASK48};
    freei = -1;
    for (int i = 0; i < QUEUE_DEPTH; i++) if (!sv_q[i] && freei < 0) freei = i;
    if (freei < 0) begin
      add_exp(mk(KIND_STATUS, ST_FULL, d, due[47:0], 1'b1));
      return;
    end
    sv_q[freei] = 1'b1;
    sdue_q[freei] = due[47:0];
    sser_q[freei] = serial_q;
    sdesc_q[freei] = d;
    serial_q++;
    add_exp(mk(KIND_STATUS, ST_QUEUED, d, due[47:0], 1'b1));
  endtask

  // Advance prediction: release due packets by due tick then age
  task automatic predict_advance(logic [23:0] el);
    int n, best;
    now_q = now_q + 48'(el);
    n = 0;
    while (n < MAX_RESULTS) begin
      best = -1;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        if (sv_q[i] && sdue_q[i] <= now_q) begin
          if (best < 0 || sdue_q[i] < sdue_q[best] ||
              (sdue_q[i] == sdue_q[best] &&
               32'(serial_q - sser_q[i]) > 32'(serial_q - sser_q[best])))
            best = i;
        end
      end
      if (best < 0) break;
      sv_q[best] = 1'b0;
      add_exp(mk(KIND_RELEASE, ST_QUEUED, sdesc_q[best], sdue_q[best], 1'b0));
      n++;
    end
    if (n > 0) exp_buf[(wr_idx - 1) % EXP_DEPTH].last = 1'b1;
  endtask

  // One input transfer, with random sender gaps
  task automatic send_item(logic rt, logic [15:0] peer, logic ta, logic ch,
                           logic [31:0] pl, logic [23:0] el);
    while ($urandom_range(99) < send_idle) @(posedge clk);
    in_valid <= 1'b1;
    in_req_type <= rt;
    in_dest_peer <= peer;
    in_to_all <= ta;
    in_channel <= ch;
    in_payload_handle <= pl;
    in_elapsed_ticks <= el;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (rt == REQ_ADV) predict_advance(el);
    else predict_enqueue(peer, ta, ch, pl);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (rd_idx != wr_idx) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Register write over the APB port, only while idle
  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    drain();
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 3'b000};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      ADDR_LATENCY: lat_q = val[23:0];
      ADDR_JITTER:  jit_q = val[23:0];
      ADDR_LOSS:    loss_q = val[15:0];
      default:      rng_q = (val == 0) ? 64'd1 : val;
    endcase
    @(posedge clk);
  endtask

  task automatic rand_enqueue();
    send_item(REQ_ENQ, 16'($urandom), 1'($urandom), 1'($urandom), $urandom, 24'($urandom));
  endtask

  task automatic rand_advance(logic [23:0] el);
    send_item(REQ_ADV, 16'($urandom), 1'($urandom), 1'($urandom), $urandom, el);
  endtask

  // Directed: extremes, broadcast, full queue, nothing due
  task automatic test_directed();
    write_reg(ADDR_SEED, 64'd0);
    send_item(REQ_ADV, 16'h0, 1'b0, 1'b0, 32'h0, 24'd5);
    send_item(REQ_ENQ, 16'hFFFF, 1'b0, 1'b0, 32'hFFFF_FFFF, 24'hFFFFFF);
    send_item(REQ_ENQ, 16'h1234, 1'b1, 1'b1, 32'h0, 24'h0);
    for (int i = 0; i < QUEUE_DEPTH + 1; i++)
      send_item(REQ_ENQ, 16'(i), 1'b0, 1'(i), 32'(i * 7), 24'd0);
    send_item(REQ_ADV, 16'h0, 1'b0, 1'b0, 32'h0, 24'd0);
    write_reg(ADDR_LATENCY, 64'hFF_FFFF);
    write_reg(ADDR_JITTER, 64'hFF_FFFF);
    write_reg(ADDR_LOSS, 64'hFFFF);
    write_reg(ADDR_SEED, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(REQ_ENQ, 16'h55AA, 1'b0, 1'b0, 32'hA5A5_5A5A, 24'd0);
    send_item(REQ_ENQ, 16'hAA55, 1'b0, 1'b1, 32'h5A5A_A5A5, 24'd0);
    send_item(REQ_ADV, 16'h0, 1'b0, 1'b0, 32'h0, 24'hFFFFFF);
  endtask

  // Long latency with large clock advances
  task automatic test_wrap();
    write_reg(ADDR_LOSS, 64'd0);
    write_reg(ADDR_JITTER, 64'd0);
    write_reg(ADDR_LATENCY, 64'hFF_FFFF);
    for (int i = 0; i < 20; i++) begin
      rand_enqueue();
      rand_advance(24'hFFFFFF);
    end
    repeat (3) rand_advance(24'hFFFFFF);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 60) rand_enqueue();
      else rand_advance(24'($urandom_range(40)));
      if (i == n / 2) drain();
    end
  endtask

  task automatic random_settings();
    write_reg(ADDR_LATENCY, 64'($urandom_range(20)));
    write_reg(ADDR_JITTER, 64'($urandom_range(15)));
    write_reg(ADDR_LOSS, 64'(16'($urandom)));
    write_reg(ADDR_SEED, {$urandom, $urandom});
  endtask

  initial begin
    lat_q = '0; jit_q = '0; loss_q = '0; rng_q = 64'd1;
    now_q = '0; serial_q = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) sv_q[i] = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_wrap();
    send_idle = 24; recv_idle = 78;
    random_settings();
    test_random(60);
    send_idle = 78; recv_idle = 24;
    random_settings();
    test_random(60);
    send_idle = 0; recv_idle = 0;
    random_settings();
    test_random(60);
    drain();
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
`default_nettype wire
